FILE: rtl/tree_path_min_edge_query_defines.svh
// Assertion macros shared by the path-minimum query modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TREE_PATH_MIN_EDGE_QUERY_DEFINES_SVH
`define TREE_PATH_MIN_EDGE_QUERY_DEFINES_SVH

// same-cycle implication
`define TPMQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpmq assertion failed");

// next-cycle implication
`define TPMQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpmq assertion failed");

`endif

FILE: rtl/tpmq_pkg.sv
// Shared types and constants for the tree path-minimum query block.
// No dependencies; used by the controller, datapath and top level.
package tpmq_pkg;

  localparam logic [1:0]  MODE_LOAD   = 2'd0;
  localparam logic [1:0]  MODE_BUILD  = 2'd1;
  localparam logic [1:0]  MODE_QUERY  = 2'd2;
  localparam logic [1:0]  MODE_NONE   = 2'd3;
  localparam logic        KIND_QUERY  = 1'b0;
  localparam logic        KIND_BUILD  = 1'b1;
  localparam logic [30:0] ROOT_WEIGHT = 31'd2000000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [30:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [30:0] path_min;
  } rsp_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_RST_CLR, OP_TAKE, OP_DISPATCH,
    OP_LD_RDA, OP_LD_WRA, OP_LD_RDB, OP_LD_WRB,
    OP_BD_CLR, OP_BD_ROOT, OP_BD_POP, OP_BD_NODE, OP_BD_ROW0, OP_BD_HEAD,
    OP_BD_LV_RD, OP_BD_LV_WR, OP_BD_ED_RD, OP_BD_ED_CHK, OP_BD_ED_VIS,
    OP_Q_RDA, OP_Q_RDB, OP_Q_ORD, OP_Q1_RD, OP_Q1_ANC, OP_Q1_CMP, OP_Q_MID,
    OP_Q2_RDX, OP_Q2_RDY, OP_Q2_UPD, OP_Q_PWX, OP_Q_PWY, OP_Q_FIN, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ld_ok;
    logic       q_skip;
    logic       clr_last;
    logic       rst_clr_last;
    logic       sp_zero;
    logic       lvl_last;
    logic       lvl_zero;
    logic       e_zero;
    logic       nb_ok;
    logic       u_zero;
    logic       xy_eq;
  } status_t;

endpackage

FILE: rtl/tpmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tpmq_ctrl.sv
// Sequencer for load, build and query requests of the path-minimum block.
// Depends on tpmq_pkg and the shared assertion macros.
`include "tree_path_min_edge_query_defines.svh"

module tpmq_ctrl
  import tpmq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_RST_CLR, ST_IDLE, ST_DISPATCH,
    ST_LD_RDA, ST_LD_WRA, ST_LD_RDB, ST_LD_WRB,
    ST_BD_CLR, ST_BD_ROOT, ST_BD_POP, ST_BD_NODE, ST_BD_ROW0, ST_BD_HEAD,
    ST_BD_LV_RD, ST_BD_LV_WR, ST_BD_ED_RD, ST_BD_ED_CHK, ST_BD_ED_VIS,
    ST_Q_RDA, ST_Q_RDB, ST_Q_ORD, ST_Q1_RD, ST_Q1_ANC, ST_Q1_CMP, ST_Q_MID,
    ST_Q2_RDX, ST_Q2_RDY, ST_Q2_UPD, ST_Q_PWX, ST_Q_PWY, ST_Q_FIN, ST_EMIT
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      ST_RST_CLR: begin
        cmd.op = OP_RST_CLR;
        if (status.rst_clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_TAKE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.op = OP_DISPATCH;
        case (status.mode)
          MODE_LOAD:  state_next = status.ld_ok ? ST_LD_RDA : ST_IDLE;
          MODE_BUILD: state_next = ST_BD_CLR;
          MODE_QUERY: state_next = status.q_skip ? ST_EMIT : ST_Q_RDA;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_LD_RDA: begin
        cmd.op = OP_LD_RDA;
        state_next = ST_LD_WRA;
      end
      ST_LD_WRA: begin
        cmd.op = OP_LD_WRA;
        state_next = ST_LD_RDB;
      end
      ST_LD_RDB: begin
        cmd.op = OP_LD_RDB;
        state_next = ST_LD_WRB;
      end
      ST_LD_WRB: begin
        cmd.op = OP_LD_WRB;
        state_next = ST_IDLE;
      end
      ST_BD_CLR: begin
        cmd.op = OP_BD_CLR;
        if (status.clr_last) state_next = ST_BD_ROOT;
      end
      ST_BD_ROOT: begin
        cmd.op = OP_BD_ROOT;
        state_next = ST_BD_POP;
      end
      ST_BD_POP: begin
        cmd.op = OP_BD_POP;
        state_next = status.sp_zero ? ST_EMIT : ST_BD_NODE;
      end
      ST_BD_NODE: begin
        cmd.op = OP_BD_NODE;
        state_next = ST_BD_ROW0;
      end
      ST_BD_ROW0: begin
        cmd.op = OP_BD_ROW0;
        state_next = ST_BD_HEAD;
      end
      ST_BD_HEAD: begin
        cmd.op = OP_BD_HEAD;
        state_next = ST_BD_LV_RD;
      end
      ST_BD_LV_RD: begin
        cmd.op = OP_BD_LV_RD;
        state_next = ST_BD_LV_WR;
      end
      ST_BD_LV_WR: begin
        cmd.op = OP_BD_LV_WR;
        state_next = status.lvl_last ? ST_BD_ED_RD : ST_BD_LV_RD;
      end
      ST_BD_ED_RD: begin
        cmd.op = OP_BD_ED_RD;
        state_next = status.e_zero ? ST_BD_POP : ST_BD_ED_CHK;
      end
      ST_BD_ED_CHK: begin
        cmd.op = OP_BD_ED_CHK;
        state_next = status.nb_ok ? ST_BD_ED_VIS : ST_BD_ED_RD;
      end
      ST_BD_ED_VIS: begin
        cmd.op = OP_BD_ED_VIS;
        state_next = ST_BD_ED_RD;
      end
      ST_Q_RDA: begin
        cmd.op = OP_Q_RDA;
        state_next = ST_Q_RDB;
      end
      ST_Q_RDB: begin
        cmd.op = OP_Q_RDB;
        state_next = ST_Q_ORD;
      end
      ST_Q_ORD: begin
        cmd.op = OP_Q_ORD;
        state_next = ST_Q1_RD;
      end
      ST_Q1_RD: begin
        cmd.op = OP_Q1_RD;
        state_next = ST_Q1_ANC;
      end
      ST_Q1_ANC: begin
        cmd.op = OP_Q1_ANC;
        if (!status.u_zero) state_next = ST_Q1_CMP;
        else state_next = status.lvl_zero ? ST_Q_MID : ST_Q1_RD;
      end
      ST_Q1_CMP: begin
        cmd.op = OP_Q1_CMP;
        state_next = status.lvl_zero ? ST_Q_MID : ST_Q1_RD;
      end
      ST_Q_MID: begin
        cmd.op = OP_Q_MID;
        state_next = status.xy_eq ? ST_EMIT : ST_Q2_RDX;
      end
      ST_Q2_RDX: begin
        cmd.op = OP_Q2_RDX;
        state_next = ST_Q2_RDY;
      end
      ST_Q2_RDY: begin
        cmd.op = OP_Q2_RDY;
        state_next = ST_Q2_UPD;
      end
      ST_Q2_UPD: begin
        cmd.op = OP_Q2_UPD;
        state_next = status.lvl_zero ? ST_Q_PWX : ST_Q2_RDX;
      end
      ST_Q_PWX: begin
        cmd.op = OP_Q_PWX;
        state_next = ST_Q_PWY;
      end
      ST_Q_PWY: begin
        cmd.op = OP_Q_PWY;
        state_next = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        cmd.op = OP_Q_FIN;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RST_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `TPMQ_ASSERT_NXT(a_take_dispatch, req_valid && !req_stall, state == ST_DISPATCH)
  `TPMQ_ASSERT_NXT(a_emit_wait, state == ST_EMIT && rsp_valid && rsp_stall,
                   state == ST_EMIT && rsp_valid)
  `TPMQ_ASSERT_NXT(a_emit_done, state == ST_EMIT && (!rsp_valid || !rsp_stall),
                   rsp_valid && state == ST_IDLE)

endmodule

FILE: rtl/tpmq_dpath.sv
// Datapath: edge store, node store, lifting tables, walk stack and query registers.
// Depends on tpmq_pkg, tpmq_ram and the shared assertion macros.
`include "tree_path_min_edge_query_defines.svh"

module tpmq_dpath
  import tpmq_pkg::*;
#(
  parameter int MAX_NODES = 32768,
  parameter int TOP_LEVEL = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  req_t        req,
  output rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int NW         = $clog2(MAX_NODES + 1);
  localparam int AW_N       = $clog2(MAX_NODES);
  localparam int EDGE_SLOTS = 2 * MAX_NODES;
  localparam int AW_E       = $clog2(EDGE_SLOTS);
  localparam int EW         = $clog2(EDGE_SLOTS + 1);
  localparam int LW         = $clog2(TOP_LEVEL + 1);
  localparam int TAW        = AW_N + LW;
  localparam int TBL_DEPTH  = MAX_NODES * (2 ** LW);

  typedef struct packed {
    logic [NW-1:0] nb;
    logic [30:0]   cost;
    logic [EW-1:0] next;
  } edge_w_t;

  typedef struct packed {
    logic            vis;
    logic [AW_N-1:0] depth;
    logic [30:0]     pw;
    logic [NW-1:0]   parent;
  } node_w_t;

  typedef struct packed {
    logic [NW-1:0] anc;
    logic [30:0]   mn;
  } tbl_w_t;

  function automatic logic [AW_N-1:0] to_idx(input logic [NW-1:0] v);
    to_idx = AW_N'(v - NW'(1));
  endfunction

  function automatic logic [30:0] min31(input logic [30:0] p, input logic [30:0] q);
    min31 = (p < q) ? p : q;
  endfunction

  logic [15:0]     cnt_reg;
  logic [16:0]     n17;
  req_t            req_q;
  logic [AW_N-1:0] clr_cnt;
  logic [EW-1:0]   et;
  logic [NW-1:0]   sp;
  logic [NW-1:0]   cur_node, cur_anc, nb, x, y, u, ux;
  logic [AW_N-1:0] cur_depth, da, dy;
  logic [30:0]     cur_min, nb_cost, um, umx, sol;
  logic [LW-1:0]   lvl;
  logic [EW-1:0]   e;
  logic            vx, vy, va, kind;
  logic [NW-1:0]   node_a_n, node_b_n;
  logic            a_ok, b_ok;

  logic            edge_we, edge_re;
  logic [AW_E-1:0] edge_waddr, edge_raddr;
  edge_w_t         edge_wdata, edge_rd;
  logic            first_we, first_re;
  logic [AW_N-1:0] first_waddr, first_raddr;
  logic [EW-1:0]   first_wdata, first_rd;
  logic            node_we, node_re;
  logic [AW_N-1:0] node_waddr, node_raddr;
  node_w_t         node_wdata, node_rd;
  logic            tbl_we, tbl_re;
  logic [TAW-1:0]  tbl_waddr, tbl_raddr;
  tbl_w_t          tbl_wdata, tbl_rd;
  logic            stk_we, stk_re;
  logic [AW_N-1:0] stk_waddr, stk_raddr;
  logic [NW-1:0]   stk_wdata, stk_rd;

  logic [NW-1:0]   lv_anc, u_now, uy_now;
  logic [30:0]     lv_min, my_now;
  logic            sp_room;

  assign n17 = (cnt_reg == 16'd0) ? 17'd1 :
               ((17'(cnt_reg) > 17'(MAX_NODES)) ? 17'(MAX_NODES) : 17'(cnt_reg));
  assign node_a_n = NW'(req_q.node_a);
  assign node_b_n = NW'(req_q.node_b);
  assign a_ok = (req_q.node_a != 16'd0) && (17'(req_q.node_a) <= n17);
  assign b_ok = (req_q.node_b != 16'd0) && (17'(req_q.node_b) <= n17);
  assign sp_room = (32'(sp) < 32'(MAX_NODES));

  assign lv_anc = (cur_anc != '0) ? tbl_rd.anc : '0;
  assign lv_min = (cur_anc != '0) ? min31(cur_min, tbl_rd.mn) : '0;
  assign u_now  = vx ? tbl_rd.anc : '0;
  assign uy_now = vy ? tbl_rd.anc : '0;
  assign my_now = vy ? tbl_rd.mn : '0;

  always_comb begin
    status.mode         = req_q.mode;
    status.ld_ok        = a_ok && b_ok && (32'(et) + 32'd2 <= 32'(EDGE_SLOTS));
    status.q_skip       = !a_ok || !b_ok || (req_q.node_a == req_q.node_b);
    status.clr_last     = (17'(clr_cnt) == n17 - 17'd1);
    status.rst_clr_last = (clr_cnt == AW_N'(MAX_NODES - 1));
    status.sp_zero      = (sp == '0);
    status.lvl_last     = (lvl == LW'(TOP_LEVEL));
    status.lvl_zero     = (lvl == '0);
    status.e_zero       = (e == '0);
    status.nb_ok        = (edge_rd.nb != '0) && (17'(edge_rd.nb) <= n17);
    status.u_zero       = (u_now == '0);
    status.xy_eq        = (x == y);
  end

  always_comb begin
    edge_we = 1'b0;  edge_re = 1'b0;  edge_waddr = '0;  edge_raddr = '0;
    edge_wdata = '0;
    first_we = 1'b0; first_re = 1'b0; first_waddr = '0; first_raddr = '0;
    first_wdata = '0;
    node_we = 1'b0;  node_re = 1'b0;  node_waddr = '0;  node_raddr = '0;
    node_wdata = '0;
    tbl_we = 1'b0;   tbl_re = 1'b0;   tbl_waddr = '0;   tbl_raddr = '0;
    tbl_wdata = '0;
    stk_we = 1'b0;   stk_re = 1'b0;   stk_waddr = '0;   stk_raddr = '0;
    stk_wdata = '0;
    case (cmd.op)
      OP_RST_CLR: begin
        first_we    = 1'b1;
        first_waddr = clr_cnt;
      end
      OP_LD_RDA: begin
        first_re    = 1'b1;
        first_raddr = to_idx(node_a_n);
      end
      OP_LD_WRA: begin
        edge_we     = 1'b1;
        edge_waddr  = AW_E'(et);
        edge_wdata  = '{nb: node_b_n, cost: req_q.edge_weight, next: first_rd};
        first_we    = 1'b1;
        first_waddr = to_idx(node_a_n);
        first_wdata = et + EW'(1);
      end
      OP_LD_RDB: begin
        first_re    = 1'b1;
        first_raddr = to_idx(node_b_n);
      end
      OP_LD_WRB: begin
        edge_we     = 1'b1;
        edge_waddr  = AW_E'(et + EW'(1));
        edge_wdata  = '{nb: node_a_n, cost: req_q.edge_weight, next: first_rd};
        first_we    = 1'b1;
        first_waddr = to_idx(node_b_n);
        first_wdata = et + EW'(2);
      end
      OP_BD_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_cnt;
      end
      OP_BD_ROOT: begin
        node_we    = 1'b1;
        node_waddr = '0;
        node_wdata = '{vis: 1'b1, depth: '0, pw: ROOT_WEIGHT, parent: '0};
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = NW'(1);
      end
      OP_BD_POP: begin
        stk_re    = (sp != '0);
        stk_raddr = AW_N'(sp - NW'(1));
      end
      OP_BD_NODE: begin
        node_re    = 1'b1;
        node_raddr = to_idx(stk_rd);
      end
      OP_BD_ROW0: begin
        tbl_we      = 1'b1;
        tbl_waddr   = {to_idx(cur_node), LW'(0)};
        tbl_wdata   = '{anc: node_rd.parent, mn: node_rd.pw};
        first_re    = 1'b1;
        first_raddr = to_idx(cur_node);
      end
      OP_BD_LV_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = {to_idx(cur_anc), LW'(lvl - LW'(1))};
      end
      OP_BD_LV_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {to_idx(cur_node), lvl};
        tbl_wdata = '{anc: lv_anc, mn: lv_min};
      end
      OP_BD_ED_RD: begin
        edge_re    = 1'b1;
        edge_raddr = AW_E'(e - EW'(1));
      end
      OP_BD_ED_CHK: begin
        node_re    = 1'b1;
        node_raddr = to_idx(edge_rd.nb);
      end
      OP_BD_ED_VIS: begin
        node_we    = !node_rd.vis;
        node_waddr = to_idx(nb);
        node_wdata = '{vis: 1'b1, depth: cur_depth + AW_N'(1), pw: nb_cost,
                       parent: cur_node};
        stk_we     = !node_rd.vis && sp_room;
        stk_waddr  = AW_N'(sp);
        stk_wdata  = nb;
      end
      OP_Q_RDA: begin
        node_re    = 1'b1;
        node_raddr = to_idx(node_a_n);
      end
      OP_Q_RDB: begin
        node_re    = 1'b1;
        node_raddr = to_idx(node_b_n);
      end
      OP_Q1_RD, OP_Q2_RDX: begin
        tbl_re    = 1'b1;
        tbl_raddr = {to_idx(x), lvl};
      end
      OP_Q1_ANC: begin
        node_re    = 1'b1;
        node_raddr = to_idx(u_now);
      end
      OP_Q2_RDY: begin
        tbl_re    = 1'b1;
        tbl_raddr = {to_idx(y), lvl};
      end
      OP_Q_PWX: begin
        node_re    = 1'b1;
        node_raddr = to_idx(x);
      end
      OP_Q_PWY: begin
        node_re    = 1'b1;
        node_raddr = to_idx(y);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_reg <= 16'd1;
      clr_cnt <= '0;
      et      <= '0;
      sp      <= '0;
    end else begin
      if (cfg_wr_en) cnt_reg <= cfg_wr_data;
      case (cmd.op)
        OP_RST_CLR: clr_cnt <= clr_cnt + AW_N'(1);
        OP_TAKE: req_q <= req;
        OP_DISPATCH: begin
          clr_cnt <= '0;
          sol     <= '0;
          kind    <= (req_q.mode == MODE_BUILD) ? KIND_BUILD : KIND_QUERY;
        end
        OP_LD_WRB: et <= et + EW'(2);
        OP_BD_CLR: clr_cnt <= clr_cnt + AW_N'(1);
        OP_BD_ROOT: sp <= NW'(1);
        OP_BD_POP: begin
          if (sp != '0) sp <= sp - NW'(1);
        end
        OP_BD_NODE: cur_node <= stk_rd;
        OP_BD_ROW0: begin
          cur_depth <= node_rd.depth;
          cur_anc   <= node_rd.parent;
          cur_min   <= node_rd.pw;
        end
        OP_BD_HEAD: begin
          e   <= first_rd;
          lvl <= LW'(1);
        end
        OP_BD_LV_WR: begin
          cur_anc <= lv_anc;
          cur_min <= lv_min;
          lvl     <= lvl + LW'(1);
        end
        OP_BD_ED_CHK: begin
          nb      <= edge_rd.nb;
          nb_cost <= edge_rd.cost;
          e       <= edge_rd.next;
        end
        OP_BD_ED_VIS: begin
          if (!node_rd.vis && sp_room) sp <= sp + NW'(1);
        end
        OP_Q_RDB: begin
          va <= node_rd.vis;
          da <= node_rd.depth;
        end
        OP_Q_ORD: begin
          if (da < node_rd.depth) begin
            x  <= node_b_n;
            y  <= node_a_n;
            vx <= node_rd.vis;
            vy <= va;
            dy <= da;
          end else begin
            x  <= node_a_n;
            y  <= node_b_n;
            vx <= va;
            vy <= node_rd.vis;
            dy <= node_rd.depth;
          end
          sol <= ROOT_WEIGHT;
          lvl <= LW'(TOP_LEVEL);
        end
        OP_Q1_ANC: begin
          u  <= u_now;
          um <= vx ? tbl_rd.mn : '0;
          if (u_now == '0) lvl <= lvl - LW'(1);
        end
        OP_Q1_CMP: begin
          if (node_rd.depth >= dy) begin
            sol <= min31(sol, um);
            x   <= u;
            vx  <= 1'b1;
          end
          lvl <= lvl - LW'(1);
        end
        OP_Q_MID: lvl <= LW'(TOP_LEVEL);
        OP_Q2_RDY: begin
          ux  <= u_now;
          umx <= vx ? tbl_rd.mn : '0;
        end
        OP_Q2_UPD: begin
          if (ux != '0 && uy_now != '0 && ux != uy_now) begin
            sol <= min31(min31(sol, umx), my_now);
            x   <= ux;
            y   <= uy_now;
            vx  <= 1'b1;
            vy  <= 1'b1;
          end
          lvl <= lvl - LW'(1);
        end
        OP_Q_PWY, OP_Q_FIN: sol <= min31(sol, node_rd.pw);
        OP_EMIT: rsp <= '{result_kind: kind, path_min: sol};
        default: begin
        end
      endcase
    end
  end

  tpmq_ram #(.WIDTH($bits(edge_w_t)), .DEPTH(EDGE_SLOTS)) u_edge_ram (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rd)
  );

  tpmq_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_first_ram (
    .clk, .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
    .re(first_re), .raddr(first_raddr), .rdata(first_rd)
  );

  tpmq_ram #(.WIDTH($bits(node_w_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rd)
  );

  tpmq_ram #(.WIDTH($bits(tbl_w_t)), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rd)
  );

  tpmq_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stk_ram (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
  );

  `TPMQ_ASSERT_IMP(a_et_even, 1'b1, et[0] == 1'b0)
  `TPMQ_ASSERT_IMP(a_et_bound, 1'b1, 32'(et) <= 32'(EDGE_SLOTS))
  `TPMQ_ASSERT_IMP(a_sp_bound, 1'b1, 32'(sp) <= 32'(MAX_NODES))

endmodule

FILE: rtl/tree_path_min_edge_query.sv
// Top level of the tree path-minimum query block: controller plus datapath.
// Depends on tpmq_pkg, tpmq_ctrl, tpmq_dpath and tpmq_ram.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     req_t (mode, nodes, weight)
//   rsp       out        rsp_valid / rsp_stall     rsp_t (result_kind, path_min)
//   cfg       in         cfg_wr_en                 cfg_wr_data (node_count)
//
// After reset the edge list heads of all MAX_NODES entries are cleared; no
// request is taken meanwhile. A load reads and then writes the list heads of
// node_a and then of node_b; a dropped load goes back to idle. A query climbs
// the lifting table level by level, with one table read per level in the first
// climb and two in the second. A build clears the n nodes in use, then writes
// one table entry per level for each node. A finished result waits in the
// output register under rsp_stall while the next request is accepted.
module tree_path_min_edge_query
  import tpmq_pkg::*;
#(
  parameter int MAX_NODES = 32768,
  parameter int TOP_LEVEL = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  tpmq_ctrl u_ctrl (
    .clk, .rst, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
    .status, .cmd
  );

  tpmq_dpath #(.MAX_NODES(MAX_NODES), .TOP_LEVEL(TOP_LEVEL)) u_dpath (
    .clk, .rst, .cmd, .status, .req, .rsp, .cfg_wr_en, .cfg_wr_data
  );

endmodule

FILE: tb/sv/tree_path_min_edge_query_tb.sv
// Testbench for tree_path_min_edge_query: directed table, then random tree phases.
// Uses tpmq_pkg types; checks every response against an in-bench path-minimum model or a typed expected value.
`timescale 1ns / 100ps

module tree_path_min_edge_query_tb;
  import tpmq_pkg::*;

  localparam int NODE_CAP   = 32768;
  localparam int SLOT_CAP   = 2 * NODE_CAP;
  localparam int LEVEL_CNT  = 17;
  localparam int CYCLE_CAP  = 3000000;
  localparam int NO_CFG     = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  tree_path_min_edge_query u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  int unsigned node_cnt = 1;
  int unsigned nb_of [SLOT_CAP];
  int unsigned cost_of [SLOT_CAP];
  int unsigned next_of [SLOT_CAP];
  int unsigned head_of [NODE_CAP];
  int unsigned stored = 0;
  bit          seen [NODE_CAP];
  int unsigned depth_of [NODE_CAP];
  int unsigned up_cost [NODE_CAP];
  int unsigned anc [NODE_CAP][LEVEL_CNT];
  int unsigned mn [NODE_CAP][LEVEL_CNT];
  int unsigned stk [NODE_CAP];

  rsp_t answers_due[$];
  bit   failed = 1'b0;
  bit   rush = 1'b0;
  bit   querying = 1'b0;
  int   taken = 0;
  int   stall_left = 0;
  bit   held_long = 1'b0;
  int   cycles = 0;
  int   sent = 0;

  function automatic int unsigned live_nodes();
    int unsigned n;
    n = node_cnt;
    if (n < 1) n = 1;
    if (n > NODE_CAP) n = NODE_CAP;
    return n;
  endfunction

  function automatic int unsigned lower(int unsigned x, int unsigned y);
    return (x < y) ? x : y;
  endfunction

  function automatic void add_link(int unsigned from, int unsigned to, int unsigned w);
    nb_of[stored] = to;
    cost_of[stored] = w;
    next_of[stored] = head_of[from - 1];
    head_of[from - 1] = stored + 1;
    stored++;
  endfunction

  function automatic void grow_tables(int unsigned n);
    int unsigned sp, node, idx, mid, e, w;
    sp = 0;
    for (int unsigned v = 0; v < n; v++) begin
      seen[v] = 0;
      depth_of[v] = 0;
      up_cost[v] = 0;
      for (int j = 0; j < LEVEL_CNT; j++) begin
        anc[v][j] = 0;
        mn[v][j] = 0;
      end
    end
    seen[0] = 1;
    up_cost[0] = ROOT_WEIGHT;
    stk[sp] = 1;
    sp++;
    while (sp > 0) begin
      sp--;
      node = stk[sp];
      idx = node - 1;
      mn[idx][0] = up_cost[idx];
      for (int j = 1; j < LEVEL_CNT; j++) begin
        mid = anc[idx][j-1];
        if (mid != 0) begin
          anc[idx][j] = anc[mid-1][j-1];
          mn[idx][j] = lower(mn[idx][j-1], mn[mid-1][j-1]);
        end else begin
          anc[idx][j] = 0;
          mn[idx][j] = 0;
        end
      end
      e = head_of[idx];
      while (e != 0) begin
        w = nb_of[e-1];
        if (w >= 1 && w <= n && !seen[w-1]) begin
          seen[w-1] = 1;
          depth_of[w-1] = depth_of[idx] + 1;
          up_cost[w-1] = cost_of[e-1];
          anc[w-1][0] = node;
          if (sp < NODE_CAP) begin
            stk[sp] = w;
            sp++;
          end
        end
        e = next_of[e-1];
      end
    end
  endfunction

  function automatic int unsigned path_min_of(int unsigned a, int unsigned b, int unsigned n);
    int unsigned x, y, sol, u, ux, uy;
    x = a;
    y = b;
    sol = ROOT_WEIGHT;
    if (a < 1 || a > n || b < 1 || b > n) return 0;
    if (a == b) return 0;
    if (depth_of[x-1] < depth_of[y-1]) begin
      x = b;
      y = a;
    end
    for (int i = LEVEL_CNT - 1; i >= 0; i--) begin
      u = anc[x-1][i];
      if (u != 0 && depth_of[u-1] >= depth_of[y-1]) begin
        sol = lower(sol, mn[x-1][i]);
        x = u;
      end
    end
    if (x == y) return sol;
    for (int i = LEVEL_CNT - 1; i >= 0; i--) begin
      ux = anc[x-1][i];
      uy = anc[y-1][i];
      if (ux != 0 && uy != 0 && ux != uy) begin
        sol = lower(sol, mn[x-1][i]);
        sol = lower(sol, mn[y-1][i]);
        x = ux;
        y = uy;
      end
    end
    sol = lower(sol, up_cost[x-1]);
    sol = lower(sol, up_cost[y-1]);
    return sol;
  endfunction

  function automatic bit tree_apply(req_t r, output rsp_t o);
    int unsigned n, a, b, w;
    n = live_nodes();
    a = r.node_a;
    b = r.node_b;
    w = r.edge_weight;
    o = '0;
    case (r.mode)
      MODE_LOAD: begin
        if (a >= 1 && a <= n && b >= 1 && b <= n && stored + 2 <= SLOT_CAP) begin
          add_link(a, b, w);
          add_link(b, a, w);
        end
        return 1'b0;
      end
      MODE_BUILD: begin
        grow_tables(n);
        o.result_kind = KIND_BUILD;
        return 1'b1;
      end
      MODE_QUERY: begin
        o.result_kind = KIND_QUERY;
        o.path_min = 31'(path_min_of(a, b, n));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // hold each request until taken; typed rows override the model answer
  task automatic offer(req_t r, bit typed = 1'b0, rsp_t want = '0);
    int gap;
    rsp_t o;
    bit has;
    gap = rush ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    has = tree_apply(r, o);
    if (typed) o = want;
    if (has) answers_due.insert(answers_due.size(), o);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(int unsigned v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 16'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_cnt = v & 16'hFFFF;
  endtask

  function automatic logic [30:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'd1999999999;
      2: return 31'h7FFFFFFF;
      3: return 31'($urandom_range(0, 100));
      default: return 31'($urandom_range(0, 1999999999));
    endcase
  endfunction

  function automatic req_t mk(logic [1:0] m, int unsigned a, int unsigned b, logic [30:0] w);
    req_t r;
    r.mode = m;
    r.node_a = 16'(a);
    r.node_b = 16'(b);
    r.edge_weight = w;
    return r;
  endfunction

  // response side: random stall per response outside rush phases, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      if (answers_due.size() == 0) begin
        $error("unexpected response kind=%0d path_min=%0d", rsp.result_kind, rsp.path_min);
        failed = 1'b1;
      end else begin
        if (rsp.result_kind !== answers_due[0].result_kind) begin
          $error("result_kind expected %0d actual %0d",
                 answers_due[0].result_kind, rsp.result_kind);
          failed = 1'b1;
        end
        if (rsp.path_min !== answers_due[0].path_min) begin
          $error("path_min expected %0d actual %0d", answers_due[0].path_min, rsp.path_min);
          failed = 1'b1;
        end
        void'(answers_due.pop_front());
      end
      taken++;
      if (!held_long && querying && taken >= 200) begin
        held_long = 1'b1;
        stall_left <= 400;
        rsp_stall <= 1'b1;
      end else if (rush) begin
        stall_left <= 0;
        rsp_stall <= 1'b0;
      end else begin
        int k;
        k = $urandom_range(0, 10);
        stall_left <= k;
        rsp_stall <= (k != 0);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    int   cfg;
    req_t r;
    bit   typed;
    rsp_t want;
  } step_t;

  initial begin
    step_t steps[$];
    int unsigned n, qn, a, b;
    rsp_t none;
    none = '0;
    steps.insert(steps.size(), '{1, mk(MODE_NONE, 1, 1, 31'd5), 1'b0, none});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 1, 2, 31'd0), 1'b1, '{KIND_QUERY, 31'd0}});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 1, 1, 31'd0), 1'b1, '{KIND_QUERY, 31'd0}});
    steps.insert(steps.size(),
                 '{0, mk(MODE_BUILD, 0, 0, 31'd0), 1'b1, '{KIND_BUILD, 31'd0}});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 1, 1, 31'h7FFFFFFF), 1'b1, '{KIND_QUERY, 31'd0}});
    steps.insert(steps.size(), '{4, mk(MODE_LOAD, 1, 2, 31'd0), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_LOAD, 2, 3, 31'h7FFFFFFF), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_LOAD, 3, 4, 31'd1999999999), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_LOAD, 4, 5, 31'd7), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_LOAD, 65535, 1, 31'd5), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_LOAD, 1, 3, 31'd9), 1'b0, none});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_BUILD, 0, 0, 31'd0), 1'b1, '{KIND_BUILD, 31'd0}});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 1, 2, 31'd0), 1'b1, '{KIND_QUERY, 31'd0}});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_QUERY, 2, 3, 31'd0), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_QUERY, 4, 1, 31'd0), 1'b0, none});
    steps.insert(steps.size(), '{NO_CFG, mk(MODE_QUERY, 3, 4, 31'd0), 1'b0, none});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 4, 65535, 31'd0), 1'b1, '{KIND_QUERY, 31'd0}});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_NONE, 65535, 65535, 31'h7FFFFFFF), 1'b0, none});
    steps.insert(steps.size(), '{65535, mk(MODE_LOAD, 32768, 32767, 31'd123), 1'b0, none});
    steps.insert(steps.size(),
                 '{NO_CFG, mk(MODE_QUERY, 40000, 1, 31'd0), 1'b1, '{KIND_QUERY, 31'd0}});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].cfg != NO_CFG) set_nodes(steps[i].cfg);
      offer(steps[i].r, steps[i].typed, steps[i].want);
    end

    while (sent < 1750) begin
      case ($urandom_range(0, 11))
        0: n = $urandom_range(0, 1);
        1: n = 200;
        default: n = $urandom_range(2, 40);
      endcase
      set_nodes(n);
      rush = ($urandom_range(0, 3) == 0);
      qn = (n < 1) ? 1 : n;
      for (int unsigned v = 2; v <= qn; v++) begin
        a = $urandom_range(1, v - 1);
        if ($urandom_range(0, 1)) offer(mk(MODE_LOAD, a, v, pick_weight()));
        else offer(mk(MODE_LOAD, v, a, pick_weight()));
        case ($urandom_range(0, 19))
          0: offer(mk(MODE_LOAD, $urandom_range(1, qn), $urandom_range(1, qn), pick_weight()));
          1: offer(mk(MODE_LOAD, $urandom_range(qn + 1, 65535), $urandom_range(0, 65535),
                      pick_weight()));
          2: offer(mk(MODE_NONE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      pick_weight()));
          default: ;
        endcase
      end
      offer(mk(MODE_BUILD, $urandom_range(0, 65535), $urandom_range(0, 65535), pick_weight()));
      querying = 1'b1;
      repeat ($urandom_range(10, 40)) begin
        a = $urandom_range(1, qn);
        b = $urandom_range(1, qn);
        case ($urandom_range(0, 9))
          0: b = a;
          1: b = $urandom_range(qn + 1, 65535);
          2: a = $urandom_range(0, 1) ? 0 : $urandom_range(qn + 1, 65535);
          default: ;
        endcase
        offer(mk(MODE_QUERY, a, b, pick_weight()));
      end
      querying = 1'b0;
      rush = 1'b0;
    end

    set_nodes(12);
    offer(mk(MODE_BUILD, 0, 0, 31'd0));
    repeat (30) offer(mk(MODE_QUERY, $urandom_range(1, 12), $urandom_range(1, 12), 31'd0));
    drain();

    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
